@@ hw/rtl/pidc_pkg.sv @@
// pidc_pkg: types, widths, codes and defaults shared by the pid controller step block
// no dependencies; used by every other file of the block

package pidc_pkg;

  localparam int DATA_W        = 32;
  localparam int THR_W         = 31;
  localparam int SLOPE_W       = 40;
  localparam int CFG_IDX_W     = 3;
  localparam int DT_SHIFT_MAX  = 16;
  localparam int DT_SHIFT_DEF  = 10;
  localparam int ALPHA_Q15_DEF = 16384;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ERR_EXT_W = DATA_W + 1;
  localparam int RAW_EXT_W = ERR_EXT_W + DT_SHIFT_MAX;
  localparam int ALPHA_W   = 17;
  localparam int FILT_W    = SLOPE_W + 1 + ALPHA_W;
  localparam int ALPHA_FRAC = 15;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 74;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_THRESHOLD   = 3'd3,
    CFG_INT_CEIL    = 3'd4,
    CFG_INT_FLOOR   = 3'd5,
    CFG_DRIVE_CEIL  = 3'd6,
    CFG_DRIVE_FLOOR = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] gain_p;
    logic [DATA_W-1:0] gain_i;
    logic [DATA_W-1:0] gain_d;
    logic [THR_W-1:0]  threshold;
    logic [DATA_W-1:0] int_ceil;
    logic [DATA_W-1:0] int_floor;
    logic [DATA_W-1:0] drive_ceil;
    logic [DATA_W-1:0] drive_floor;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INTEG,
    ST_FILT,
    ST_SLOPE,
    ST_MUL_DL,
    ST_MUL_DH,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_DL,
    MUL_DH
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    logic     calc_int;
    logic     calc_filt;
    logic     upd_state;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     load_out;
  } cmd_t;

endpackage

@@ hw/rtl/pidc_in_if.sv @@
// pidc_in_if: input channel carrying setpoint and measurement per transaction
// depends on pidc_pkg

interface pidc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pidc_pkg::DATA_W-1:0] setpoint;
  logic [pidc_pkg::DATA_W-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

@@ hw/rtl/pidc_out_if.sv @@
// pidc_out_if: result channel carrying the clamped drive and clamp flags
// depends on pidc_pkg

interface pidc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pidc_pkg::DATA_W-1:0] control_value;
  logic                        integral_clamped;
  logic                        drive_clamped;

  modport source (output valid, output control_value, output integral_clamped,
                  output drive_clamped, input ready);
  modport sink   (input valid, input control_value, input integral_clamped,
                  input drive_clamped, output ready);
endinterface

@@ hw/rtl/pid_controller_step_top.sv @@
// pid_controller_step_top: positional pid step with integral separation and filtered slope
// depends on pidc_pkg, pidc_in_if, pidc_out_if, pidc_cfg_regs, pidc_ctrl, pidc_datapath
// result: registered from the accumulator in the done state, once the output register is free
// one transaction is processed at a time, the sequencer running
//   four products through one shared 33x33 multiplier, plus a stall while a result waits
// reset: asynchronous, clears gains to zero, limits to full range, and pid state to zero

module pid_controller_step_top #(
  parameter int unsigned DT_SHIFT  = pidc_pkg::DT_SHIFT_DEF,
  parameter int unsigned ALPHA_Q15 = pidc_pkg::ALPHA_Q15_DEF,
  parameter int unsigned FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]    cfg_data_i,
  pidc_in_if.sink                        in_i,
  pidc_out_if.source                     out_o
);

  pidc_pkg::cfg_t cfg;
  pidc_pkg::cmd_t cmd;

  pidc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  pidc_datapath #(
    .DT_SHIFT  (DT_SHIFT),
    .ALPHA_Q15 (ALPHA_Q15),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .setpoint_i         (in_i.setpoint),
    .measured_i         (in_i.measured),
    .control_value_o    (out_o.control_value),
    .integral_clamped_o (out_o.integral_clamped),
    .drive_clamped_o    (out_o.drive_clamped)
  );

  a_one_tick_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a tick is in flight");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("waiting result overwritten");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  a_err_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.calc_err |-> $past(in_i.valid && in_i.ready))
    else $error("error stage without an accepted transaction");

endmodule

@@ hw/rtl/pidc_cfg_regs.sv @@
// pidc_cfg_regs: gain, threshold and limit registers behind the write port
// depends on pidc_pkg

module pidc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]    cfg_data_i,
  output pidc_pkg::cfg_t                 cfg_o
);

  pidc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.threshold   <= '1;
      cfg_q.int_ceil    <= {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
      cfg_q.int_floor   <= {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
      cfg_q.drive_ceil  <= {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
      cfg_q.drive_floor <= {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
    end else if (cfg_we_i) begin
      case (pidc_pkg::cfg_idx_e'(cfg_idx_i))
        pidc_pkg::CFG_GAIN_P:      cfg_q.gain_p      <= cfg_data_i;
        pidc_pkg::CFG_GAIN_I:      cfg_q.gain_i      <= cfg_data_i;
        pidc_pkg::CFG_GAIN_D:      cfg_q.gain_d      <= cfg_data_i;
        pidc_pkg::CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[pidc_pkg::THR_W-1:0];
        pidc_pkg::CFG_INT_CEIL:    cfg_q.int_ceil    <= cfg_data_i;
        pidc_pkg::CFG_INT_FLOOR:   cfg_q.int_floor   <= cfg_data_i;
        pidc_pkg::CFG_DRIVE_CEIL:  cfg_q.drive_ceil  <= cfg_data_i;
        pidc_pkg::CFG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/pidc_ctrl.sv @@
// pidc_ctrl: sequencer for one control tick and output valid flag
// depends on pidc_pkg; drives pidc_datapath through cmd_t

module pidc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output pidc_pkg::cmd_t cmd_o
);

  pidc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pidc_pkg::ST_IDLE:   if (in_valid_i) state_d = pidc_pkg::ST_ERR;
      pidc_pkg::ST_ERR:    state_d = pidc_pkg::ST_INTEG;
      pidc_pkg::ST_INTEG:  state_d = pidc_pkg::ST_FILT;
      pidc_pkg::ST_FILT:   state_d = pidc_pkg::ST_SLOPE;
      pidc_pkg::ST_SLOPE:  state_d = pidc_pkg::ST_MUL_DL;
      pidc_pkg::ST_MUL_DL: state_d = pidc_pkg::ST_MUL_DH;
      pidc_pkg::ST_MUL_DH: state_d = pidc_pkg::ST_ACC;
      pidc_pkg::ST_ACC:    state_d = pidc_pkg::ST_DONE;
      pidc_pkg::ST_DONE:   if (out_free) state_d = pidc_pkg::ST_IDLE;
      default:             state_d = pidc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = pidc_pkg::MUL_P;
    cmd_o.acc_op  = pidc_pkg::ACC_HOLD;
    in_ready_o    = 1'b0;
    case (state_q)
      pidc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      pidc_pkg::ST_ERR: begin
        cmd_o.calc_err = 1'b1;
      end
      pidc_pkg::ST_INTEG: begin
        cmd_o.calc_int = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = pidc_pkg::MUL_P;
      end
      pidc_pkg::ST_FILT: begin
        cmd_o.calc_filt = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = pidc_pkg::MUL_I;
        cmd_o.acc_op    = pidc_pkg::ACC_LOAD;
      end
      pidc_pkg::ST_SLOPE: begin
        cmd_o.upd_state = 1'b1;
        cmd_o.acc_op    = pidc_pkg::ACC_ADD;
      end
      pidc_pkg::ST_MUL_DL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_DL;
      end
      pidc_pkg::ST_MUL_DH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_DH;
        cmd_o.acc_op  = pidc_pkg::ACC_ADD;
      end
      pidc_pkg::ST_ACC: begin
        cmd_o.acc_op = pidc_pkg::ACC_ADD_HI;
      end
      pidc_pkg::ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pidc_datapath.sv @@
// pidc_datapath: error, integral, filtered slope, shared multiplier and accumulator
// depends on pidc_pkg; sequenced by pidc_ctrl through cmd_t

module pidc_datapath #(
  parameter int unsigned DT_SHIFT  = pidc_pkg::DT_SHIFT_DEF,
  parameter int unsigned ALPHA_Q15 = pidc_pkg::ALPHA_Q15_DEF,
  parameter int unsigned FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pidc_pkg::cmd_t              cmd_i,
  input  pidc_pkg::cfg_t              cfg_i,
  input  logic [pidc_pkg::DATA_W-1:0] setpoint_i,
  input  logic [pidc_pkg::DATA_W-1:0] measured_i,
  output logic [pidc_pkg::DATA_W-1:0] control_value_o,
  output logic                        integral_clamped_o,
  output logic                        drive_clamped_o
);

  localparam int DW  = pidc_pkg::DATA_W;
  localparam int EW  = pidc_pkg::ERR_EXT_W;
  localparam int RW  = pidc_pkg::RAW_EXT_W;
  localparam int SW  = pidc_pkg::SLOPE_W;
  localparam int FW  = pidc_pkg::FILT_W;
  localparam int MW  = pidc_pkg::MUL_W;
  localparam int PW  = pidc_pkg::PROD_W;
  localparam int AW  = pidc_pkg::ACC_W;
  localparam int AF  = pidc_pkg::ALPHA_FRAC;

  localparam logic signed [RW-1:0] RAW_MAX = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0] RAW_MIN = ~RAW_MAX;
  localparam logic signed [pidc_pkg::ALPHA_W-1:0] ALPHA_S =
    pidc_pkg::ALPHA_W'(ALPHA_Q15);
  localparam logic signed [FW-1:0] FILT_HALF = FW'(1) <<< (AF - 1);

  // per-tick working registers
  logic signed [DW-1:0] sp_q, ms_q, err_q, isum_q;
  logic                 iflag_q;
  logic signed [SW-1:0] raw_q;
  logic signed [FW-1:0] filt_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [DW-1:0]        cv_q;
  logic                 icl_q, dcl_q;

  // controller state kept across ticks
  logic signed [DW-1:0] last_err_q, integ_q;
  logic signed [SW-1:0] fs_q;

  // error
  logic signed [EW-1:0] diff_e;
  logic signed [DW-1:0] err_d;

  assign diff_e = $signed({sp_q[DW-1], sp_q}) - $signed({ms_q[DW-1], ms_q});
  always_comb begin
    if (diff_e[EW-1] != diff_e[EW-2]) begin
      err_d = diff_e[EW-1] ? $signed({1'b1, {(DW-1){1'b0}}})
                           : $signed({1'b0, {(DW-1){1'b1}}});
    end else begin
      err_d = diff_e[DW-1:0];
    end
  end

  // integral with separation and clamp, raw slope
  logic [DW-1:0]        mag;
  logic                 thr_hit;
  logic signed [DW-1:0] istep;
  logic signed [EW-1:0] isum_e, ceil_e, floor_e;
  logic signed [DW-1:0] isum_d;
  logic                 iflag_d;
  logic signed [EW-1:0] de;
  logic signed [RW-1:0] de_sh;
  logic signed [SW-1:0] raw_d;

  assign mag     = err_q[DW-1] ? (~err_q + DW'(1)) : err_q;
  assign thr_hit = mag < {1'b0, cfg_i.threshold};
  assign istep   = err_q >>> DT_SHIFT;
  assign isum_e  = $signed({integ_q[DW-1], integ_q})
                 + (thr_hit ? $signed({istep[DW-1], istep}) : $signed(EW'(0)));
  assign ceil_e  = $signed({cfg_i.int_ceil[DW-1], cfg_i.int_ceil});
  assign floor_e = $signed({cfg_i.int_floor[DW-1], cfg_i.int_floor});

  always_comb begin
    iflag_d = 1'b1;
    if (isum_e > ceil_e) begin
      isum_d = cfg_i.int_ceil;
    end else if (isum_e < floor_e) begin
      isum_d = cfg_i.int_floor;
    end else begin
      isum_d  = isum_e[DW-1:0];
      iflag_d = 1'b0;
    end
  end

  assign de    = $signed({err_q[DW-1], err_q}) - $signed({last_err_q[DW-1], last_err_q});
  assign de_sh = $signed({{(RW-EW){de[EW-1]}}, de}) <<< DT_SHIFT;

  always_comb begin
    if (de_sh > RAW_MAX) begin
      raw_d = RAW_MAX[SW-1:0];
    end else if (de_sh < RAW_MIN) begin
      raw_d = RAW_MIN[SW-1:0];
    end else begin
      raw_d = de_sh[SW-1:0];
    end
  end

  // low-pass filter: fs + round(alpha * (raw - fs) / 2^15)
  logic signed [SW:0]   fdiff;
  logic signed [FW-1:0] filt_d;
  logic signed [FW-1:0] filt_rnd;
  logic signed [SW-1:0] slope_d;

  assign fdiff    = $signed({raw_q[SW-1], raw_q}) - $signed({fs_q[SW-1], fs_q});
  assign filt_d   = fdiff * ALPHA_S;
  assign filt_rnd = (filt_q + FILT_HALF) >>> AF;
  assign slope_d  = fs_q + filt_rnd[SW-1:0];

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d;

  always_comb begin
    case (cmd_i.mul_sel)
      pidc_pkg::MUL_P: begin
        mul_a = $signed({cfg_i.gain_p[DW-1], cfg_i.gain_p});
        mul_b = $signed({err_q[DW-1], err_q});
      end
      pidc_pkg::MUL_I: begin
        mul_a = $signed({cfg_i.gain_i[DW-1], cfg_i.gain_i});
        mul_b = $signed({isum_q[DW-1], isum_q});
      end
      pidc_pkg::MUL_DL: begin
        mul_a = $signed({cfg_i.gain_d[DW-1], cfg_i.gain_d});
        mul_b = $signed({1'b0, fs_q[DW-1:0]});
      end
      pidc_pkg::MUL_DH: begin
        mul_a = $signed({cfg_i.gain_d[DW-1], cfg_i.gain_d});
        mul_b = $signed({{(MW-(SW-DW)){fs_q[SW-1]}}, fs_q[SW-1:DW]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // accumulator
  logic signed [AW-1:0] prod_ext, acc_d;

  assign prod_ext = $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});

  always_comb begin
    case (cmd_i.acc_op)
      pidc_pkg::ACC_HOLD:   acc_d = acc_q;
      pidc_pkg::ACC_LOAD:   acc_d = prod_ext;
      pidc_pkg::ACC_ADD:    acc_d = acc_q + prod_ext;
      pidc_pkg::ACC_ADD_HI: acc_d = acc_q + (prod_ext <<< DW);
      default:              acc_d = acc_q;
    endcase
  end

  // output scaling and drive clamp
  logic signed [AW-1:0] v, dceil, dfloor;
  logic [DW-1:0]        cv_d;
  logic                 dcl_d;

  assign v      = acc_q >>> FRAC_BITS;
  assign dceil  = $signed({{(AW-DW){cfg_i.drive_ceil[DW-1]}}, cfg_i.drive_ceil});
  assign dfloor = $signed({{(AW-DW){cfg_i.drive_floor[DW-1]}}, cfg_i.drive_floor});

  always_comb begin
    dcl_d = 1'b1;
    if (v > dceil) begin
      cv_d = cfg_i.drive_ceil;
    end else if (v < dfloor) begin
      cv_d = cfg_i.drive_floor;
    end else begin
      cv_d  = v[DW-1:0];
      dcl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sp_q <= setpoint_i;
      ms_q <= measured_i;
    end
    if (cmd_i.calc_err) err_q <= err_d;
    if (cmd_i.calc_int) begin
      isum_q  <= isum_d;
      iflag_q <= iflag_d;
      raw_q   <= raw_d;
    end
    if (cmd_i.calc_filt) filt_q <= filt_d;
    if (cmd_i.mul_en) prod_q <= prod_d;
    acc_q <= acc_d;
    if (cmd_i.load_out) begin
      cv_q  <= cv_d;
      icl_q <= iflag_q;
      dcl_q <= dcl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
      fs_q       <= '0;
    end else if (cmd_i.upd_state) begin
      last_err_q <= err_q;
      integ_q    <= isum_q;
      fs_q       <= slope_d;
    end
  end

  assign control_value_o    = cv_q;
  assign integral_clamped_o = icl_q;
  assign drive_clamped_o    = dcl_q;

endmodule
